@@ src/pgc_pkg.sv @@
// types, constants and arithmetic helpers for the polynomial gain correction block
package pgc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CoefN  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TermsW = 3;

  localparam logic [CfgIdxW-1:0] RegNumTerms  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDivMode   = 3'd7;

  localparam logic signed [31:0] CoefZeroReset = 32'sd65536;
  localparam logic signed [31:0] QOne          = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] e_in;
  } pgc_in_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic signed [31:0] e_out;
    logic               div_zero;
    logic               overflow;
  } pgc_out_t;

  // item travelling down the chain of horner-free power cells
  // acc holds the constant plus up to five 47 bit terms without wrapping
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] e;
    logic signed [31:0] p;
    logic signed [49:0] acc;
    logic               ovf;
  } pgc_lane_t;

  // round a 64 bit q32 product to q16 with ties toward plus infinity
  function automatic logic signed [47:0] round_q16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic is_sat(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

@@ src/pgc_cell.sv @@
// one cell of the chain: next power of x and one rounded term added in
module pgc_cell
  import pgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pgc_lane_t          lane_i,
  input  logic               use_i,
  input  logic signed [31:0] coef_i,
  output logic               valid_o,
  output pgc_lane_t          lane_o
);
  // stage a: power product; stage b: term product
  logic               va_q;
  pgc_lane_t          la_q;
  pgc_lane_t          la_d;
  logic signed [63:0] pprod;
  logic signed [63:0] pr_ext;
  logic signed [31:0] p_new;
  logic               use_a_q;
  logic signed [63:0] tprod;
  logic signed [47:0] term;
  pgc_lane_t          lb_d;

  assign pprod  = 64'(lane_i.p) * 64'(lane_i.x);
  assign pr_ext = 64'(round_q16(pprod));
  assign p_new  = sat32(pr_ext);

  always_comb begin
    la_d = lane_i;
    if (use_i) begin
      la_d.p   = p_new;
      la_d.ovf = lane_i.ovf | is_sat(pr_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la_q <= la_d;
      use_a_q <= use_i;
      lane_o <= lb_d;
    end
  end

  assign tprod = 64'(coef_i) * 64'(la_q.p);
  assign term  = round_q16(tprod);

  always_comb begin
    lb_d = la_q;
    if (use_a_q) lb_d.acc = la_q.acc + 50'(term);
  end
endmodule

@@ src/pgc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module pgc_div
  import pgc_pkg::*;
#(
  parameter int unsigned NumW = 49,
  parameter int unsigned DenW = 33,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);
  logic [NumW-1:0] q_q   [NumW+1];
  logic [DenW:0]   r_q   [NumW+1];
  logic [DenW-1:0] d_q   [NumW+1];
  logic [TagW-1:0] t_q   [NumW+1];

  always_comb begin
    q_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    t_q[0] = tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic [DenW:0]   sh;
    logic [DenW+1:0] df;
    assign sh = {r_q[s][DenW-1:0], q_q[s][NumW-1]};
    assign df = {1'b0, sh} - {2'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
        if (!df[DenW+1]) begin
          r_q[s+1] <= df[DenW:0];
          q_q[s+1] <= {q_q[s][NumW-2:0], 1'b1};
        end else begin
          r_q[s+1] <= sh;
          q_q[s+1] <= {q_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = q_q[NumW];
  assign tag_o = t_q[NumW];
  logic unused;
  assign unused = rst_ni;
endmodule

@@ src/polynomial_gain_correction_top.sv @@
// top level of the polynomial gain correction pipeline
//
// channel | dir | handshake              | payload
// in      | in  | in_valid_i / in_stall_o  | pgc_in_t (x, y, e)
// out     | out | out_valid_o / out_stall_i| pgc_out_t (y, e, div_zero, overflow)
// cfg     | in  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one item per cycle while the output is not stalled; a result passes through two
// registers per power cell, then the factor stage, the product stage,
// 49 divider stages and the output register
// reset clears all valid bits and loads the register reset values
// the whole pipe advances together; a stalled output freezes every stage,
// the output register parts the two sides only through its own slot
module polynomial_gain_correction_top
  import pgc_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pgc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgc_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  localparam int unsigned NCell = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;
  localparam int unsigned NumW  = 49;
  localparam int unsigned DenW  = 33;

  logic signed [31:0] coef_q [CoefN];
  logic [TermsW-1:0]  num_terms_q;
  logic               div_mode_q;
  logic [TermsW-1:0]  terms;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoefN; i++) coef_q[i] <= (i == 0) ? CoefZeroReset : '0;
      num_terms_q <= TermsW'(1);
      div_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegNumTerms) num_terms_q <= cfg_data_i[TermsW-1:0];
      else if (cfg_idx_i == RegDivMode) div_mode_q <= cfg_data_i[0];
      else coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // clamp term count to 1..MAX_TERMS
  always_comb begin
    if (num_terms_q == '0) terms = TermsW'(1);
    else if (32'(num_terms_q) > MAX_TERMS) terms = TermsW'(MAX_TERMS);
    else terms = num_terms_q;
  end

  // whole pipe moves when output slot is free or empty
  logic en;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // chain of power cells
  logic      cv [NCell+1];
  pgc_lane_t cl [NCell+1];
  always_comb begin
    cv[0] = in_valid_i;
    cl[0].x = in_data_i.x_in;
    cl[0].y = in_data_i.y_in;
    cl[0].e = in_data_i.e_in;
    cl[0].p = QOne;
    cl[0].acc = 50'(coef_q[0]);
    cl[0].ovf = 1'b0;
  end
  for (genvar k = 0; k < NCell; k++) begin : g_cell
    logic use_k;
    assign use_k = (32'(terms) > k + 1);
    pgc_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(cv[k]), .lane_i(cl[k]),
      .use_i(use_k), .coef_i(coef_q[(k + 1) % CoefN]),
      .valid_o(cv[k+1]), .lane_o(cl[k+1])
    );
  end

  // factor stage
  logic               fv_q;
  logic signed [31:0] f_q, y_q, e_q;
  logic [32:0]        af_q;
  logic               fo_q;
  logic signed [31:0] fsat;
  assign fsat = sat32(64'(cl[NCell].acc));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (en) fv_q <= cv[NCell];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q  <= fsat;
      af_q <= fsat[31] ? 33'(-34'(fsat)) : 33'(fsat);
      fo_q <= cl[NCell].ovf | is_sat(64'(cl[NCell].acc));
      y_q  <= cl[NCell].y;
      e_q  <= cl[NCell].e;
    end
  end

  // product stage for multiply mode and operand setup for divide mode
  logic               mv_q, mo_q, mneg_y, mneg_e, mneg_f, mdz_q, mdiv_q;
  logic signed [63:0] py_q, pe_q;
  logic [NumW-1:0]    ny, ne;
  logic [DenW-1:0]    dd;
  logic [31:0]        ay, ae;
  assign ay = y_q[31] ? 32'(-y_q) : 32'(y_q);
  assign ae = e_q[31] ? 32'(-e_q) : 32'(e_q);
  // numerator 2*|a|*2^16 + d, denominator 2*d, so quotient rounds half away
  assign ny = {ay, 17'd0} + NumW'(af_q);
  assign ne = {ae, 17'd0} + NumW'(af_q);
  assign dd = {af_q[31:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q <= 1'b0;
    else if (en) mv_q <= fv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      py_q   <= 64'(y_q) * 64'(f_q);
      pe_q   <= 64'(e_q) * $signed({31'd0, af_q});
      mo_q   <= fo_q;
      mdiv_q <= div_mode_q;
      mdz_q  <= div_mode_q && (f_q == '0);
      mneg_y <= y_q[31] ^ f_q[31];
      mneg_e <= e_q[31];
      mneg_f <= f_q[31];
    end
  end

  // divider operands registered alongside the products
  logic [NumW-1:0] ny_q, ne_q;
  logic [DenW-1:0] dd_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ny_q <= ny;
      ne_q <= ne;
      dd_q <= dd;
    end
  end

  // dividers; the tag of the y divider carries the multiply result path
  localparam int unsigned TagW = 64 + 64 + 6;
  logic [NumW-1:0] qy, qe;
  logic [TagW-1:0] tg_in, tg_y, tg_e;
  assign tg_in = {py_q, pe_q, mo_q, mdiv_q, mdz_q, mneg_y, mneg_e, mneg_f};
  pgc_div #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .num_i(ny_q), .den_i(mdz_q ? DenW'(2) : dd_q),
    .tag_i(tg_in), .quo_o(qy), .tag_o(tg_y)
  );
  pgc_div #(.NumW(NumW), .DenW(DenW), .TagW(1)) u_div_e (
    .clk_i, .rst_ni, .en_i(en), .num_i(ne_q), .den_i(mdz_q ? DenW'(2) : dd_q),
    .tag_i(1'b0), .quo_o(qe), .tag_o(tg_e[0])
  );
  assign tg_e[TagW-1:1] = '0;

  logic dv [NumW+1];
  assign dv[0] = mv_q;
  for (genvar s = 0; s < NumW; s++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv[s+1] <= 1'b0;
      else if (en) dv[s+1] <= dv[s];
    end
  end

  // final stage: rounding, signs, saturation
  logic signed [63:0] ty, te;
  logic               to, tdiv, tdz, tny, tne, tfn;
  assign {ty, te, to, tdiv, tdz, tny, tne, tfn} = tg_y;
  logic signed [63:0] ry, re, sy, se;
  logic               ovf_y;
  pgc_out_t res;
  always_comb begin
    ry = 64'(round_q16(ty));
    re = 64'(round_q16(te));
    sy = tny ? -$signed({15'd0, qy}) : $signed({15'd0, qy});
    se = tne ? -$signed({15'd0, qe}) : $signed({15'd0, qe});
    ovf_y = 1'b0;
    res.div_zero = 1'b0;
    if (!tdiv) begin
      res.y_out = sat32(ry);
      res.e_out = sat32(re);
      res.overflow = to | is_sat(ry) | is_sat(re);
    end else if (tdz) begin
      res.y_out = '0;
      res.e_out = '0;
      res.div_zero = 1'b1;
      res.overflow = to;
    end else begin
      res.y_out = sat32(sy);
      res.e_out = sat32(se);
      ovf_y = is_sat(sy);
      // non-negative y over a negative factor: quotient saturates before the sign flip
      if (tny && tfn && (qy > NumW'(32'h7fff_ffff))) begin
        res.y_out = 32'sh8000_0001;
        ovf_y = 1'b1;
      end
      res.overflow = to | ovf_y | is_sat(se);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= dv[NumW];
  end
  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= res;
  end

  logic unused_e;
  assign unused_e = ^tg_e;
endmodule
